@@ sv/csds_pkg.sv @@
package csds_pkg;

    localparam int LANE_W       = 5;
    localparam int LANE_IDX_W   = 3;
    localparam int TIME_W       = 32;
    localparam int CFG_W        = 10;
    localparam int CFG_IDX_W    = 3;
    localparam int QUEUE_DEPTH  = 32;
    localparam int LANES        = 5;

    localparam logic [9:0] FRET_LEAD_RST   = 10'd50;
    localparam logic [9:0] STRUM_PULSE_RST = 10'd40;
    localparam logic [9:0] CHORD_WIN_RST   = 10'd30;
    localparam logic [7:0] TICK_RST        = 8'd2;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE      = 3'd0,
        CFG_FRET_LEAD   = 3'd1,
        CFG_STRUM_PULSE = 3'd2,
        CFG_CHORD_WIN   = 3'd3,
        CFG_TICK        = 3'd4,
        CFG_ADVANCE     = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic              opcode;
        logic [TIME_W-1:0] frame_time_ms;
        logic [TIME_W-1:0] strike_time_ms;
        logic [LANE_W-1:0] pressed_frets;
    } in_item_t;

    typedef struct packed {
        logic [6:0] drive_mask;
        logic       send;
    } out_item_t;

    // one queued deadline
    typedef struct packed {
        logic [TIME_W-1:0] at;
        logic [LANE_W-1:0] lanes;
    } qentry_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctl_t;

    // a is earlier than b on the wrapping clock
    function automatic logic earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1];
    endfunction

endpackage

@@ sv/chord_strum_deadline_scheduler_unit.sv @@
// Chord strum deadline scheduler.
// Input channel item/item_valid/item_stall carries a detector frame or a tick;
// every accepted beat yields exactly one result beat on result/result_valid/
// result_stall (drive mask and send flag). Registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them while the block is
// idle, the block itself does not enforce it. Per item the sequencer steps:
// take the beat, age the chord and test the pulse end, push when a chord
// commits, pop each due press entry and then each due strum entry off the
// cell rows (each queue also needs a step to find its end), then per lane
// the release probe (all cells compare against the lane's release time and
// register the hit, the OR is taken in the release step), then load the
// output register.
// item_stall is high while an item is in progress. The result sits in the
// output register until taken; the next item may be accepted meanwhile and
// waits at its end if the earlier result is still stalled.
// Reset clears both queues, the chord, lane and strum state, both clocks and
// restores the register defaults; no clearing pass is needed.
module chord_strum_deadline_scheduler_unit #(
    parameter int QUEUE_DEPTH = csds_pkg::QUEUE_DEPTH,
    parameter int LANES       = csds_pkg::LANES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  csds_pkg::in_item_t                  item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output csds_pkg::out_item_t                 result,
    input  logic                                cfg_we,
    input  logic [csds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csds_pkg::CFG_W-1:0]          cfg_data
);

    localparam int TW = csds_pkg::TIME_W;
    localparam int LW = csds_pkg::LANE_W;
    localparam int IW = csds_pkg::LANE_IDX_W;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [LW-1:0] LANE_MASK = LW'((1 << LANES) - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_AGE, ST_PUSH, ST_PPOP, ST_SPOP, ST_PROBE, ST_RELEASE, ST_OUT
    } state_t;

    // configuration
    logic       enable_reg;
    logic [9:0] fret_lead_reg, strum_pulse_reg, chord_win_reg, advance_reg;
    logic [7:0] tick_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            fret_lead_reg   <= csds_pkg::FRET_LEAD_RST;
            strum_pulse_reg <= csds_pkg::STRUM_PULSE_RST;
            chord_win_reg   <= csds_pkg::CHORD_WIN_RST;
            tick_reg        <= csds_pkg::TICK_RST;
            advance_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                csds_pkg::CFG_ENABLE:      enable_reg      <= cfg_data[0];
                csds_pkg::CFG_FRET_LEAD:   fret_lead_reg   <= cfg_data;
                csds_pkg::CFG_STRUM_PULSE: strum_pulse_reg <= cfg_data;
                csds_pkg::CFG_CHORD_WIN:   chord_win_reg   <= cfg_data;
                csds_pkg::CFG_TICK:        tick_reg        <= cfg_data[7:0];
                csds_pkg::CFG_ADVANCE:     advance_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    state_t          state_reg;
    logic [TW-1:0]   now_reg, strike_reg, chord_start_reg, strum_end_reg;
    logic [TW-1:0]   fire_reg, press_at_reg, soonest_reg, last_strum_reg;
    logic            chord_open_reg, strum_on_reg, strum_up_reg;
    logic [LW-1:0]   chord_lanes_reg, lanes_active_reg, prev_reg, pending_reg;
    logic [TW-1:0]   release_time [LW];
    logic [IW-1:0]   lane_reg;
    logic            result_valid_reg;
    csds_pkg::out_item_t result_reg;
    logic            out_load;

    // queue hookup
    csds_pkg::q_ctl_t  pq_ctl, sq_ctl;
    csds_pkg::qentry_t pq_push, sq_push, pq_head, sq_head;
    logic [CW-1:0]     pq_count, sq_count;
    logic              pq_full, sq_full, pq_need, sq_need;
    logic [TW-1:0]     probe_time;

    // deadline choice at commit
    logic            pushed_later;
    logic [TW-1:0]   push_press_at, push_strum_due;
    logic [TW-1:0]   age;
    logic            age_ok, press_due, strum_due;
    logic [LW-1:0]   cur, rises, falls;

    assign pushed_later   = (sq_count != '0) && csds_pkg::earlier(press_at_reg, soonest_reg);
    assign push_press_at  = pushed_later ? soonest_reg : press_at_reg;
    assign push_strum_due = pushed_later ? soonest_reg + TW'(fret_lead_reg) : strike_reg;

    assign pq_push    = '{at: push_press_at, lanes: chord_lanes_reg};
    assign sq_push    = '{at: push_strum_due, lanes: chord_lanes_reg};
    assign press_due  = (pq_count != '0) && !csds_pkg::earlier(fire_reg, pq_head.at);
    assign strum_due  = (sq_count != '0) && !csds_pkg::earlier(fire_reg, sq_head.at);
    assign pq_ctl     = '{push: state_reg == ST_PUSH, pop: state_reg == ST_PPOP && press_due};
    assign sq_ctl     = '{push: state_reg == ST_PUSH, pop: state_reg == ST_SPOP && strum_due};
    assign probe_time = release_time[lane_reg];

    assign age    = now_reg - chord_start_reg;
    assign age_ok = !age[TW-1] && (age >= TW'(chord_win_reg));
    assign cur    = item.pressed_frets & LANE_MASK;
    assign rises  = cur & ~prev_reg;
    assign falls  = prev_reg & ~cur;

    // output register takes a new beat once the old one is gone
    assign out_load = (state_reg == ST_OUT) && (!result_valid_reg || !result_stall);

    csds_queue #(.DEPTH(QUEUE_DEPTH)) u_press_q (
        .clk(clk), .rst_n(rst_n), .ctl(pq_ctl), .push_data(pq_push),
        .probe_time(probe_time), .probe_lane(lane_reg),
        .head(pq_head), .count(pq_count), .full(pq_full), .need(pq_need)
    );

    csds_queue #(.DEPTH(QUEUE_DEPTH)) u_strum_q (
        .clk(clk), .rst_n(rst_n), .ctl(sq_ctl), .push_data(sq_push),
        .probe_time(probe_time), .probe_lane(lane_reg),
        .head(sq_head), .count(sq_count), .full(sq_full), .need(sq_need)
    );

    // release times: payload, written on falling edges
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && item_valid && item.opcode == csds_pkg::OP_FRAME)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (falls[i])
                begin
                    release_time[i] <= item.strike_time_ms;
                end
            end
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            now_reg          <= '0;
            strike_reg       <= '0;
            chord_start_reg  <= '0;
            strum_end_reg    <= '0;
            fire_reg         <= '0;
            press_at_reg     <= '0;
            soonest_reg      <= '0;
            last_strum_reg   <= '0;
            chord_open_reg   <= 1'b0;
            strum_on_reg     <= 1'b0;
            strum_up_reg     <= 1'b0;
            chord_lanes_reg  <= '0;
            lanes_active_reg <= '0;
            prev_reg         <= '0;
            pending_reg      <= '0;
            lane_reg         <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        if (item.opcode == csds_pkg::OP_TICK)
                        begin
                            now_reg    <= now_reg + TW'(tick_reg);
                            strike_reg <= strike_reg + TW'(tick_reg);
                        end
                        else
                        begin
                            now_reg     <= item.frame_time_ms;
                            strike_reg  <= item.strike_time_ms;
                            prev_reg    <= cur;
                            pending_reg <= pending_reg | falls;
                            if (rises != '0)
                            begin
                                if (!chord_open_reg)
                                begin
                                    chord_open_reg  <= 1'b1;
                                    chord_start_reg <= item.frame_time_ms;
                                    chord_lanes_reg <= rises;
                                end
                                else
                                begin
                                    chord_lanes_reg <= chord_lanes_reg | rises;
                                end
                            end
                        end
                        state_reg <= ST_AGE;
                    end
                end
                ST_AGE:
                begin
                    fire_reg     <= now_reg + TW'(advance_reg);
                    press_at_reg <= strike_reg - TW'(fret_lead_reg);
                    soonest_reg  <= last_strum_reg + TW'(strum_pulse_reg);
                    if (strum_on_reg && !csds_pkg::earlier(now_reg, strum_end_reg))
                    begin
                        strum_on_reg <= 1'b0;
                    end
                    if (chord_open_reg && age_ok)
                    begin
                        if (pq_full || sq_full)
                        begin
                            chord_open_reg  <= 1'b0;
                            chord_lanes_reg <= '0;
                            state_reg       <= ST_PPOP;
                        end
                        else
                        begin
                            state_reg <= ST_PUSH;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_PPOP;
                    end
                end
                ST_PUSH:
                begin
                    last_strum_reg  <= push_strum_due;
                    chord_open_reg  <= 1'b0;
                    chord_lanes_reg <= '0;
                    state_reg       <= ST_PPOP;
                end
                ST_PPOP:
                begin
                    if (press_due)
                    begin
                        lanes_active_reg <= pq_head.lanes & LANE_MASK;
                    end
                    else
                    begin
                        state_reg <= ST_SPOP;
                    end
                end
                ST_SPOP:
                begin
                    if (strum_due)
                    begin
                        strum_on_reg  <= 1'b1;
                        strum_up_reg  <= !strum_up_reg;
                        strum_end_reg <= now_reg + TW'(strum_pulse_reg);
                    end
                    else
                    begin
                        lane_reg  <= '0;
                        state_reg <= ST_PROBE;
                    end
                end
                ST_PROBE:
                begin
                    state_reg <= ST_RELEASE;
                end
                ST_RELEASE:
                begin
                    if (pending_reg[lane_reg]
                        && !csds_pkg::earlier(fire_reg, release_time[lane_reg])
                        && !prev_reg[lane_reg] && !pq_need && !sq_need)
                    begin
                        lanes_active_reg[lane_reg] <= 1'b0;
                        pending_reg[lane_reg]      <= 1'b0;
                    end
                    if (lane_reg == IW'(LANES - 1))
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        lane_reg  <= lane_reg + IW'(1);
                        state_reg <= ST_PROBE;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        result_reg.send       <= enable_reg;
                        result_reg.drive_mask <= {strum_on_reg && strum_up_reg,
                                                  strum_on_reg && !strum_up_reg,
                                                  lanes_active_reg & LANE_MASK};
                        state_reg             <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ sv/csds_cell.sv @@
module csds_cell (
    input  logic                                clk,
    input  csds_pkg::cell_ctl_t                 ctl,
    input  csds_pkg::qentry_t                   shift_in,
    input  csds_pkg::qentry_t                   load_data,
    input  logic                                occupied,
    input  logic [csds_pkg::TIME_W-1:0]         probe_time,
    input  logic [csds_pkg::LANE_IDX_W-1:0]     probe_lane,
    output csds_pkg::qentry_t                   entry,
    output logic                                hit
);

    csds_pkg::qentry_t entry_reg;
    logic              hit_reg;

    // entry storage: load at the tail, shift towards the head on pop
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            entry_reg <= load_data;
        end
        else if (ctl.shift)
        begin
            entry_reg <= shift_in;
        end
        hit_reg <= occupied && entry_reg.lanes[probe_lane]
                   && !csds_pkg::earlier(probe_time, entry_reg.at);
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

@@ sv/csds_queue.sv @@
module csds_queue #(
    parameter int DEPTH = csds_pkg::QUEUE_DEPTH,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  csds_pkg::q_ctl_t                    ctl,
    input  csds_pkg::qentry_t                   push_data,
    input  logic [csds_pkg::TIME_W-1:0]         probe_time,
    input  logic [csds_pkg::LANE_IDX_W-1:0]     probe_lane,
    output csds_pkg::qentry_t                   head,
    output logic [CW-1:0]                       count,
    output logic                                full,
    output logic                                need
);

    logic [CW-1:0]     count_reg;
    csds_pkg::qentry_t entries [DEPTH];
    logic [DEPTH-1:0]  hits;

    // row of cells, head at cell 0
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        csds_pkg::cell_ctl_t cctl;
        csds_pkg::qentry_t   nb;
        assign cctl.load  = ctl.push && (count_reg == CW'(k));
        assign cctl.shift = ctl.pop;
        if (k == DEPTH - 1)
        begin : g_last
            assign nb = entries[k];
        end
        else
        begin : g_mid
            assign nb = entries[k + 1];
        end
        csds_cell u_cell (
            .clk        (clk),
            .ctl        (cctl),
            .shift_in   (nb),
            .load_data  (push_data),
            .occupied   (count_reg > CW'(k)),
            .probe_time (probe_time),
            .probe_lane (probe_lane),
            .entry      (entries[k]),
            .hit        (hits[k])
        );
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.push && !full)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (ctl.pop && count_reg != '0)
        begin
            count_reg <= count_reg - CW'(1);
        end
    end

    assign head  = entries[0];
    assign count = count_reg;
    assign full  = (count_reg == CW'(DEPTH));
    assign need  = |hits;

endmodule
